>>> sv/stt_pkg.sv
// Shared types, result codes and constants of the sleep timer table.
package stt_pkg;

    localparam int THREAD_BITS = 8;
    localparam int PRIO_BITS   = 8;
    localparam int MS_BITS     = 32;
    localparam int RATE_BITS   = 20;
    localparam int TICK_BITS   = 32;
    // Milliseconds times 1000 needs ten more bits than the millisecond count.
    localparam int PROD_BITS   = MS_BITS + 10;

    localparam logic [RATE_BITS-1:0] TICK_RATE_RESET = RATE_BITS'(1000);

    localparam logic CMD_SLEEP = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef enum logic [2:0] {
        KIND_ACCEPTED  = 3'd0,
        KIND_IGNORED   = 3'd1,
        KIND_FULL      = 3'd2,
        KIND_RELEASED  = 3'd3,
        KIND_TICK_DONE = 3'd4
    } kind_t;

    typedef struct packed {
        logic                   cmd;
        logic [THREAD_BITS-1:0] thread_id;
        logic [PRIO_BITS-1:0]   priority_req;
        logic                   has_current;
        logic [MS_BITS-1:0]     duration_ms;
    } in_item_t;

    typedef struct packed {
        kind_t                  kind;
        logic [THREAD_BITS-1:0] released_thread;
        logic                   higher_released;
        logic                   last;
    } out_item_t;

    // One table entry as held by a cell.
    typedef struct packed {
        logic [THREAD_BITS-1:0] thread;
        logic [PRIO_BITS-1:0]   prio;
        logic [TICK_BITS-1:0]   remaining;
    } entry_t;

    // Per-cell control: shift takes the right neighbor, load takes new data.
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

    // Multiply milliseconds by 1000 as 1024 - 16 - 8.
    function automatic logic [PROD_BITS-1:0] mul_ms_per_s(input logic [MS_BITS-1:0] ms);
        logic [PROD_BITS-1:0] w;
        w = PROD_BITS'(ms);
        return (w << 10) - (w << 4) - (w << 3);
    endfunction

endpackage

>>> sv/stt_cell.sv
// One cell of the entry chain: holds one entry, loads or shifts from its neighbor.
module stt_cell
    import stt_pkg::*;
(
    input  logic      aclk,
    input  cell_ctl_t ctl,
    input  entry_t    nbr,
    input  entry_t    load_data,
    output entry_t    q
);

    entry_t q_reg;

    // Load wins over shift: a push lands behind the shifted survivors.
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            q_reg <= load_data;
        end else if (ctl.shift) begin
            q_reg <= nbr;
        end
    end

    assign q = q_reg;

endmodule

>>> sv/stt_div.sv
// Iterative restoring divider, two quotient bits per cycle, zero divisor taken as one.
module stt_div
    import stt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [PROD_BITS-1:0] dividend,
    input  logic [RATE_BITS-1:0] divisor,
    output logic                 done,
    output logic [PROD_BITS-1:0] quotient
);

    localparam int STEPS = (PROD_BITS + 1) / 2;
    localparam int QW    = 2 * STEPS;
    localparam int CW    = $clog2(STEPS + 1);

    logic [QW-1:0]        quo_reg, quo_next;
    logic [RATE_BITS-1:0] rem_reg, rem_next;
    logic [RATE_BITS-1:0] dsr_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    // Two shift-compare-subtract steps per cycle.
    always_comb begin
        logic [RATE_BITS:0] t;
        logic [RATE_BITS-1:0] r;
        logic [QW-1:0] q;
        r = rem_reg;
        q = quo_reg;
        for (int k = 0; k < 2; k++) begin
            t = {r, q[QW-1]};
            q = {q[QW-2:0], 1'b0};
            if (t >= {1'b0, dsr_reg}) begin
                t = t - {1'b0, dsr_reg};
                q[0] = 1'b1;
            end
            r = t[RATE_BITS-1:0];
        end
        rem_next = r;
        quo_next = q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(STEPS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath holds no reset.
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= QW'(dividend);
            rem_reg <= '0;
            dsr_reg <= (divisor == '0) ? RATE_BITS'(1) : divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[PROD_BITS-1:0];

endmodule

>>> sv/sleep_timer_table.sv
// Top level of the sleep timer table: control sequencer, cell chain and divider.
//
// Sleeping threads sit in a chain of SLOTS cells in insertion order, the oldest
// at cell 0. A sleep request forms ms*1000, starts the divider, runs the
// 2-bit-per-cycle division by tick_rate, then appends the entry at the tail and
// presents the single result. A tick takes the item, visits each live entry once
// and then presents the tick-done result: each cycle the head entry leaves cell 0
// and the whole chain shifts one place, a surviving entry is written back at the
// tail with its count decremented, a released one is presented on the result
// channel (so a stalled result channel stalls the pass).
// One item is in work at a time; s_ready is high only between items, and the
// result register lets the next item enter while the last result waits.
// tick_rate may be written at any time the block is idle; a zero is used as one.
module sleep_timer_table
    import stt_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [RATE_BITS-1:0] cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data
);

    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int IDX_W = $clog2(SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_TICK
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     pass_reg, pass_next;
    logic                 higher_reg, higher_next;
    logic                 m_valid_reg, m_valid_next;
    out_item_t            m_data_reg, m_data_next;
    in_item_t             req_reg, req_next;
    logic [PROD_BITS-1:0] prod_reg, prod_next;
    logic [RATE_BITS-1:0] tick_rate_reg;

    logic                 div_start;
    logic                 div_done;
    logic [PROD_BITS-1:0] div_quo;
    logic [TICK_BITS-1:0] ticks;

    logic                 out_free;
    logic                 shift_en;
    logic                 load_en;
    logic [IDX_W-1:0]     load_idx;
    entry_t               load_data;
    entry_t               head;
    logic [TICK_BITS-1:0] head_rem;

    cell_ctl_t            cell_ctl [SLOTS];
    entry_t               cell_q   [SLOTS];

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign head     = cell_q[0];
    assign head_rem = head.remaining - TICK_BITS'(1);

    // Saturate the quotient to the tick width.
    assign ticks = (|div_quo[PROD_BITS-1:TICK_BITS]) ? '1 : div_quo[TICK_BITS-1:0];

    stt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (tick_rate_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Build the chain; the tail cell's neighbor input is a don't-care.
    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        entry_t nbr;
        if (i == SLOTS - 1) begin : g_tail
            assign nbr = load_data;
        end else begin : g_mid
            assign nbr = cell_q[i+1];
        end
        assign cell_ctl[i].shift = shift_en;
        assign cell_ctl[i].load  = load_en && (load_idx == IDX_W'(i));
        stt_cell u_cell (
            .aclk      (aclk),
            .ctl       (cell_ctl[i]),
            .nbr       (nbr),
            .load_data (load_data),
            .q         (cell_q[i])
        );
    end

    // Sequence one item at a time.
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        pass_next    = pass_reg;
        higher_next  = higher_reg;
        req_next     = req_reg;
        prod_next    = prod_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        div_start    = 1'b0;
        shift_en     = 1'b0;
        load_en      = 1'b0;
        load_idx     = count_reg[IDX_W-1:0];
        load_data    = '{thread: req_reg.thread_id, prio: req_reg.priority_req,
                         remaining: ticks};

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next  = s_data;
                    prod_next = mul_ms_per_s(s_data.duration_ms);
                    if (s_data.cmd == CMD_SLEEP) begin
                        state_next = S_MUL;
                    end else begin
                        state_next  = S_TICK;
                        pass_next   = count_reg;
                        higher_next = 1'b0;
                    end
                end
            end
            S_MUL: begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_done && out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{kind: KIND_ACCEPTED, released_thread: '0,
                                     higher_released: 1'b0, last: 1'b1};
                    if (ticks == '0) begin
                        m_data_next.kind = KIND_IGNORED;
                    end else if (count_reg == CNT_W'(SLOTS)) begin
                        m_data_next.kind = KIND_FULL;
                    end else begin
                        load_en    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            S_TICK: begin
                if (pass_reg == '0) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_data_next  = '{kind: KIND_TICK_DONE, released_thread: '0,
                                         higher_released: higher_reg, last: 1'b1};
                        state_next   = S_IDLE;
                    end
                end else if (head_rem == '0) begin
                    // Release the head: pop it and report the thread.
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_data_next  = '{kind: KIND_RELEASED, released_thread: head.thread,
                                         higher_released: 1'b0, last: 1'b0};
                        shift_en     = 1'b1;
                        count_next   = count_reg - CNT_W'(1);
                        pass_next    = pass_reg - CNT_W'(1);
                        if (!req_reg.has_current || (head.prio < req_reg.priority_req)) begin
                            higher_next = 1'b1;
                        end
                    end
                end else begin
                    // Rotate the survivor to the tail with its count decremented.
                    shift_en  = 1'b1;
                    load_en   = 1'b1;
                    load_idx  = IDX_W'(count_reg - CNT_W'(1));
                    load_data = '{thread: head.thread, prio: head.prio, remaining: head_rem};
                    pass_next = pass_reg - CNT_W'(1);
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pass_reg      <= '0;
            higher_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
            tick_rate_reg <= TICK_RATE_RESET;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pass_reg    <= pass_next;
            higher_reg  <= higher_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                tick_rate_reg <= cfg_data;
            end
        end
        m_data_reg <= m_data_next;
        req_reg    <= req_next;
        prod_reg   <= prod_next;
    end

    // The table never holds more entries than cells.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(SLOTS))
        else $error("entry count exceeds table size");

    // A tick pass never adds entries.
    a_tick_no_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TICK) |=> (count_reg <= $past(count_reg)))
        else $error("entry count grew during a tick");

    // A release is never the final result of its item.
    a_release_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.kind == KIND_RELEASED)) |-> !m_data_reg.last)
        else $error("release result marked last");

    // The remaining pass length never exceeds the live entries.
    a_pass_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TICK) |-> (pass_reg <= count_reg))
        else $error("tick pass longer than table");

endmodule
